@@ hdl/kvsa_pkg.sv @@
// Package for the LRU slot allocator: request and result structs, action,
// kind, status and register codes. No dependencies.
package kvsa_pkg;

	localparam logic [1:0] ACT_ACQUIRE = 2'd0;
	localparam logic [1:0] ACT_RELEASE = 2'd1;
	localparam logic [1:0] ACT_WRITE   = 2'd2;
	localparam logic [1:0] ACT_QUERY   = 2'd3;

	localparam logic [1:0] KIND_OWNED  = 2'd0;
	localparam logic [1:0] KIND_FREE   = 2'd1;
	localparam logic [1:0] KIND_STOLEN = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_SLOT  = 2'd1;
	localparam logic [1:0] ST_BAD_LAYER = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	localparam logic [1:0] REG_LAYER_COUNT    = 2'd0;
	localparam logic [1:0] REG_CONTEXT_LENGTH = 2'd1;
	localparam logic [1:0] REG_ACTIVE_SLOTS   = 2'd2;

	localparam logic [6:0]  LAYER_COUNT_RST    = 7'd32;
	localparam logic [12:0] CONTEXT_LENGTH_RST = 13'd4096;
	localparam logic [3:0]  ACTIVE_SLOTS_RST   = 4'd8;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] session_id;
		logic [3:0]  slot_index;
		logic [6:0]  layer_index;
	} req_t;

	typedef struct packed {
		logic [2:0]  granted_slot;
		logic [1:0]  acquire_kind;
		logic [12:0] position;
		logic [8:0]  buffer_index;
		logic        position_advanced;
		logic [3:0]  free_slots;
		logic [1:0]  status;
	} res_t;

endpackage

@@ hdl/kv_slot_allocator_lru_top.sv @@
// LRU slot allocator top: config registers, request sequencer, result register.
// Sequence from accept to result: an acquire reads every active slot's record (S_SCAN),
// then writes back (S_AWB); other actions read and evaluate one record (S_EVAL); a bad
// slot on other actions skips both; all end in S_OUT, loading the result unless stalled.
// One request at a time: in_stall is high outside S_IDLE until the result loads.
// Reset: owners free, records read as zero, touch clock zero, registers at defaults.
module kv_slot_allocator_lru_top
	import kvsa_pkg::*;
#(
	parameter int MAX_SLOTS   = 8,
	parameter int MAX_LAYERS  = 64,
	parameter int MAX_CONTEXT = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  req_t        in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output res_t        out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int SAW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int SCW = $clog2(MAX_SLOTS + 1);
	localparam int PW  = $clog2(MAX_CONTEXT + 1);
	localparam int LW  = MAX_LAYERS;
	localparam int RW  = 32 + PW + 64 + LW;
	localparam int FCW = $clog2(MAX_SLOTS + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_AWB  = 3'd2;
	localparam logic [2:0] S_EVAL = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [6:0]  layer_count_q;
	logic [12:0] context_length_q;
	logic [3:0]  active_slots_q;

	logic [2:0]           state_q;
	req_t                 req_q;
	res_t                 res_q;
	logic                 out_valid_q;
	res_t                 out_q;
	logic [MAX_SLOTS-1:0] owner_valid_q;
	logic [63:0]          touch_q;

	logic [SCW-1:0] scan_idx_q;
	logic           ev_s1;
	logic [SAW-1:0] ev_idx_s1;
	logic           found_q;
	logic [SAW-1:0] own_idx_q;
	logic [PW-1:0]  own_pos_q;
	logic [LW-1:0]  own_map_q;
	logic [SAW-1:0] min_idx_q;
	logic [63:0]    min_stamp_q;

	logic [SCW-1:0] nslots;
	logic [6:0]     nl;
	logic [PW-1:0]  nctx;
	logic [LW-1:0]  lmask;

	logic           mem_wr_en;
	logic [SAW-1:0] mem_wr_addr;
	logic [RW-1:0]  mem_wr_data;
	logic           mem_rd_en;
	logic [SAW-1:0] mem_rd_addr;
	logic [RW-1:0]  mem_rd_data;

	logic [31:0]    rd_sess;
	logic [PW-1:0]  rd_pos;
	logic [63:0]    rd_stamp;
	logic [LW-1:0]  rd_map;

	logic           free_any;
	logic [SAW-1:0] free_idx;
	logic [FCW-1:0] free_cnt;
	logic           accept;
	logic           issue;
	logic           slot_bad;
	logic           out_load;

	logic [SAW-1:0] g_idx;
	logic [1:0]     g_kind;
	logic [PW-1:0]  g_pos;
	logic [LW-1:0]  g_map;

	logic [SAW-1:0] e_slot;
	logic           e_layer_bad;
	logic           e_full;
	logic [LW-1:0]  e_map_or;
	logic           e_done;
	logic [11:0]    e_bidx;

	// effective register values
	always_comb begin
		if (active_slots_q == 4'd0) begin
			nslots = SCW'(1);
		end else if (32'(active_slots_q) > MAX_SLOTS) begin
			nslots = SCW'(MAX_SLOTS);
		end else begin
			nslots = SCW'(active_slots_q);
		end
		if (layer_count_q == 7'd0) begin
			nl = 7'd1;
		end else if (32'(layer_count_q) > MAX_LAYERS) begin
			nl = 7'(MAX_LAYERS);
		end else begin
			nl = layer_count_q;
		end
		if (context_length_q == 13'd0) begin
			nctx = PW'(1);
		end else if (32'(context_length_q) > MAX_CONTEXT) begin
			nctx = PW'(MAX_CONTEXT);
		end else begin
			nctx = PW'(context_length_q);
		end
		for (int i = 0; i < LW; i++) begin
			lmask[i] = (i < 32'(nl));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layer_count_q    <= LAYER_COUNT_RST;
			context_length_q <= CONTEXT_LENGTH_RST;
			active_slots_q   <= ACTIVE_SLOTS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LAYER_COUNT:    layer_count_q    <= cfg_data[6:0];
				REG_CONTEXT_LENGTH: context_length_q <= cfg_data[12:0];
				REG_ACTIVE_SLOTS:   active_slots_q   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	assign {rd_sess, rd_pos, rd_stamp, rd_map} = mem_rd_data;

	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		free_cnt = '0;
		for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
			if (i < 32'(nslots) && !owner_valid_q[i]) begin
				free_any = 1'b1;
				free_idx = SAW'(i);
			end
		end
		for (int i = 0; i < MAX_SLOTS; i++) begin
			if (i < 32'(nslots) && !owner_valid_q[i]) begin
				free_cnt = free_cnt + FCW'(1);
			end
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign slot_bad = 32'(in_data.slot_index) >= 32'(nslots);
	assign issue    = (state_q == S_SCAN) && (scan_idx_q < nslots);
	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	// acquire grant
	always_comb begin
		if (found_q) begin
			g_idx  = own_idx_q;
			g_kind = KIND_OWNED;
			g_pos  = own_pos_q;
			g_map  = own_map_q;
		end else if (free_any) begin
			g_idx  = free_idx;
			g_kind = KIND_FREE;
			g_pos  = '0;
			g_map  = '0;
		end else begin
			g_idx  = min_idx_q;
			g_kind = KIND_STOLEN;
			g_pos  = '0;
			g_map  = '0;
		end
	end

	// single-slot evaluation
	assign e_slot      = SAW'(req_q.slot_index);
	assign e_layer_bad = 32'(req_q.layer_index) >= 32'(nl);
	assign e_full      = rd_pos >= nctx;
	assign e_map_or    = rd_map | (LW'(1) << req_q.layer_index);
	assign e_done      = (e_map_or & lmask) == lmask;
	assign e_bidx      = 12'(req_q.slot_index) * 12'(nl) + 12'(req_q.layer_index);

	always_comb begin
		mem_rd_en   = 1'b0;
		mem_rd_addr = '0;
		mem_wr_en   = 1'b0;
		mem_wr_addr = '0;
		mem_wr_data = mem_rd_data;
		unique case (state_q)
			S_IDLE: begin
				mem_rd_en   = accept && (in_data.action == ACT_ACQUIRE || !slot_bad);
				mem_rd_addr = (in_data.action == ACT_ACQUIRE) ? '0
					: SAW'(in_data.slot_index);
			end
			S_SCAN: begin
				mem_rd_en   = issue;
				mem_rd_addr = scan_idx_q[SAW-1:0];
			end
			S_AWB: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = g_idx;
				mem_wr_data = {req_q.session_id, g_pos, touch_q + 64'd1, g_map};
			end
			S_EVAL: begin
				mem_wr_addr = e_slot;
				if (req_q.action == ACT_RELEASE) begin
					mem_wr_en   = 1'b1;
					mem_wr_data = {rd_sess, PW'(0), rd_stamp, LW'(0)};
				end else if (req_q.action == ACT_WRITE && !e_layer_bad && !e_full) begin
					mem_wr_en   = 1'b1;
					mem_wr_data = {rd_sess, e_done ? rd_pos + PW'(1) : rd_pos,
						touch_q + 64'd1, e_done ? LW'(0) : e_map_or};
				end
			end
			default: ;
		endcase
	end

	kvsa_slot_mem #(
		.DEPTH(MAX_SLOTS),
		.AW   (SAW),
		.W    (RW)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data),
		.rd_en  (mem_rd_en),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			owner_valid_q <= '0;
			touch_q       <= '0;
			out_valid_q   <= 1'b0;
			ev_s1         <= 1'b0;
			scan_idx_q    <= '0;
			found_q       <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						found_q    <= 1'b0;
						scan_idx_q <= SCW'(1);
						ev_s1      <= 1'b1;
						if (in_data.action == ACT_ACQUIRE) begin
							state_q <= S_SCAN;
						end else if (slot_bad) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_EVAL;
						end
					end
				end
				S_SCAN: begin
					ev_s1 <= issue;
					if (issue) begin
						scan_idx_q <= scan_idx_q + SCW'(1);
					end
					if (ev_s1 && owner_valid_q[ev_idx_s1] && rd_sess == req_q.session_id
						&& !found_q) begin
						found_q <= 1'b1;
					end
					if (ev_s1 && !issue) begin
						state_q <= S_AWB;
					end
				end
				S_AWB: begin
					owner_valid_q[g_idx] <= 1'b1;
					touch_q              <= touch_q + 64'd1;
					state_q              <= S_OUT;
				end
				S_EVAL: begin
					if (req_q.action == ACT_RELEASE) begin
						owner_valid_q[e_slot] <= 1'b0;
					end else if (req_q.action == ACT_WRITE && !e_layer_bad && !e_full) begin
						touch_q <= touch_q + 64'd1;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q     <= in_data;
			ev_idx_s1 <= '0;
			res_q     <= '0;
			res_q.granted_slot <= in_data.slot_index[2:0];
			if (in_data.action != ACT_ACQUIRE && slot_bad) begin
				res_q.status <= ST_BAD_SLOT;
			end
		end
		if (state_q == S_SCAN) begin
			if (issue) begin
				ev_idx_s1 <= scan_idx_q[SAW-1:0];
			end
			if (ev_s1) begin
				if (owner_valid_q[ev_idx_s1] && rd_sess == req_q.session_id && !found_q) begin
					own_idx_q <= ev_idx_s1;
					own_pos_q <= rd_pos;
					own_map_q <= rd_map;
				end
				if (ev_idx_s1 == '0 || rd_stamp < min_stamp_q) begin
					min_idx_q   <= ev_idx_s1;
					min_stamp_q <= rd_stamp;
				end
			end
		end
		if (state_q == S_AWB) begin
			res_q.granted_slot <= 3'(g_idx);
			res_q.acquire_kind <= g_kind;
			res_q.position     <= 13'(g_pos);
		end
		if (state_q == S_EVAL) begin
			unique case (req_q.action)
				ACT_WRITE: begin
					res_q.position <= 13'(rd_pos);
					if (e_layer_bad) begin
						res_q.status <= ST_BAD_LAYER;
					end else if (e_full) begin
						res_q.status <= ST_FULL;
					end else begin
						res_q.buffer_index      <= e_bidx[8:0];
						res_q.position_advanced <= e_done;
					end
				end
				ACT_QUERY: begin
					res_q.position <= 13'(rd_pos);
					if (e_layer_bad) begin
						res_q.status <= ST_BAD_LAYER;
					end else begin
						res_q.buffer_index <= e_bidx[8:0];
					end
				end
				default: ;
			endcase
		end
		if (out_load) begin
			out_q            <= res_q;
			out_q.free_slots <= 4'(free_cnt);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_OUT)
		else $error("result raised outside result state");

	a_touch_step: assert property (@(posedge clk) disable iff (!arst_n)
		touch_q == $past(touch_q) || touch_q == $past(touch_q) + 64'd1)
		else $error("touch clock jumped");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> scan_idx_q <= nslots)
		else $error("scan index beyond active slots");

	a_grant_owns: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_AWB |=> $countones(owner_valid_q) >= $past($countones(owner_valid_q)))
		else $error("acquire lost an owner");

endmodule

@@ hdl/kvsa_slot_mem.sv @@
// Slot record memory: one write port, one registered read port.
// Entries never written read as zero (per-entry init bits). Uses kvsa_pkg.
module kvsa_slot_mem
	import kvsa_pkg::*;
#(
	parameter int DEPTH = 8,
	parameter int AW    = 3,
	parameter int W     = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [W-1:0]  wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [W-1:0]  rd_data
);

	logic [W-1:0]     mem [DEPTH];
	logic [DEPTH-1:0] init_q;
	logic [W-1:0]     rd_q;
	logic             rd_init_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q    <= '0;
			rd_init_q <= 1'b0;
		end else begin
			if (wr_en) begin
				init_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_init_q <= init_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_init_q ? rd_q : '0;

endmodule
